[sv/hsvbgr_pkg.sv]
package hsvbgr_pkg;

  // Full-scale levels
  localparam logic [7:0]  FULL8  = 8'd255;
  localparam logic [15:0] FULL16 = 16'd65025;

  // Half-up rounding offsets: floor((2N + D) / 2D) = floor((N + floor(D/2)) / D)
  localparam logic [7:0]  RND8  = 8'd127;
  localparam logic [15:0] RND16 = 16'd32512;

  // Reciprocals of 255: exact for dividends below 2^16 and 2^24 respectively
  localparam logic [16:0] RECIP_LO       = 17'd65794;     // ceil(2^24 / 255)
  localparam int          RECIP_LO_SHIFT = 24;
  localparam logic [25:0] RECIP_HI       = 26'd33686019;  // ceil(2^33 / 255)
  localparam int          RECIP_HI_SHIFT = 33;

  // Hue sector boundaries on 6*hue
  localparam logic [10:0] EDGE_1 = 11'd255;
  localparam logic [10:0] EDGE_2 = 11'd510;
  localparam logic [10:0] EDGE_3 = 11'd765;
  localparam logic [10:0] EDGE_4 = 11'd1020;
  localparam logic [10:0] EDGE_5 = 11'd1275;
  localparam logic [10:0] EDGE_6 = 11'd1530;

  // Sector codes
  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;

  // After hue decode
  typedef struct packed {
    logic [7:0]  sat;
    logic [7:0]  val;
    logic        last;
    logic [2:0]  sector;
    logic [7:0]  rem;
    logic [15:0] num_p;
  } stage1_t;

  // After saturation weights
  typedef struct packed {
    logic [7:0]  val;
    logic        last;
    logic        sat_zero;
    logic [2:0]  sector;
    logic [15:0] num_p;
    logic [15:0] wgt_q;
    logic [15:0] wgt_t;
  } stage2_t;

  // After level products and p rounding
  typedef struct packed {
    logic [7:0]  val;
    logic        last;
    logic        sat_zero;
    logic [2:0]  sector;
    logic [8:0]  lvl_p;
    logic [23:0] num_q;
    logic [23:0] num_t;
  } stage3_t;

  // After first division by 255
  typedef struct packed {
    logic [7:0]  val;
    logic        last;
    logic        sat_zero;
    logic [2:0]  sector;
    logic [8:0]  lvl_p;
    logic [15:0] quo_q;
    logic [15:0] quo_t;
  } stage4_t;

  // Finished pixel
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } pixel_t;

  // Saturate a level to one byte
  function automatic logic [7:0] clip8(input logic [8:0] lvl);
    logic [7:0] res;
    res = lvl[8] ? FULL8 : lvl[7:0];
    return res;
  endfunction

endpackage

[sv/hsvbgr_if.sv]
interface hsvbgr_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;
  logic       last_in;

  modport source (output valid, output hue, output saturation, output brightness,
                  output last_in, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input last_in, output ready);
endinterface

interface hsvbgr_bgr_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       last_out;

  modport source (output valid, output blue, output green, output red,
                  output last_out, input ready);
  modport sink   (input valid, input blue, input green, input red,
                  input last_out, output ready);
endinterface

[sv/hsv_to_bgr_pixel_converter.sv]
// HSV to BGR pixel converter. Takes one 8-bit hue/saturation/value pixel per
// clock while the stages have room and returns blue, green and red bytes,
// with the last flag carried alongside. The five register stages are: hue
// sector decode, saturation weights, level products, a first and a second
// reciprocal divide by 255; the output register is the last stage. Each
// stage holds its item only while the stage after it is full, so bubbles
// are squeezed out and input stays ready while the output waits, until all
// five stages hold items. Levels are rounded half up from the exact ratios.
module hsv_to_bgr_pixel_converter (
  input logic                clk_i,
  input logic                rst_ni,
  hsvbgr_hsv_if.sink         hsv_i,
  hsvbgr_bgr_if.source       bgr_o
);
  import hsvbgr_pkg::*;

  logic    mid_valid;
  logic    mid_ready;
  stage2_t mid_data;
  pixel_t  pix;

  hsvbgr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hsv_i.valid),
    .ready_o (hsv_i.ready),
    .hue_i   (hsv_i.hue),
    .sat_i   (hsv_i.saturation),
    .val_i   (hsv_i.brightness),
    .last_i  (hsv_i.last_in),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid_data)
  );

  hsvbgr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (mid_data),
    .valid_o (bgr_o.valid),
    .ready_i (bgr_o.ready),
    .data_o  (pix)
  );

  assign bgr_o.blue     = pix.blue;
  assign bgr_o.green    = pix.green;
  assign bgr_o.red      = pix.red;
  assign bgr_o.last_out = pix.last;

  // An empty output stage must leave the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bgr_o.valid |-> hsv_i.ready)
    else $error("input blocked with empty output stage");

  // Input may only stall behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_i.ready |-> (bgr_o.valid && !bgr_o.ready))
    else $error("input stalled without output backpressure");

  // One channel always carries the brightest level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bgr_o.valid |->
      ((bgr_o.blue >= bgr_o.green && bgr_o.blue >= bgr_o.red) ||
       (bgr_o.green >= bgr_o.blue && bgr_o.green >= bgr_o.red) ||
       (bgr_o.red >= bgr_o.blue && bgr_o.red >= bgr_o.green)))
    else $error("no channel at the peak level");

  // Handoff between front and back must not lose the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_valid && !mid_ready) |=> mid_valid)
    else $error("stalled item dropped between stages");

endmodule

[sv/hsvbgr_front.sv]
module hsvbgr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          hue_i,
  input  logic [7:0]          sat_i,
  input  logic [7:0]          val_i,
  input  logic                last_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsvbgr_pkg::stage2_t data_o
);
  import hsvbgr_pkg::*;

  logic          s1_valid_q;
  stage1_t       s1_q, s1_d;
  logic          s1_ready;
  logic          s2_valid_q;
  stage2_t       s2_q, s2_d;
  logic          s2_ready;
  logic [10:0]   six_h;
  logic [10:0]   base;
  logic [10:0]   rem_full;
  logic [15:0]   prod_q;
  logic [15:0]   prod_t;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  // Split hue into sector and remainder
  assign six_h    = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  always_comb begin
    s1_d.sector = SECTOR_0;
    base        = '0;
    if (six_h >= EDGE_6) begin
      s1_d.sector = SECTOR_0;
      base        = EDGE_6;
    end else if (six_h >= EDGE_5) begin
      s1_d.sector = SECTOR_5;
      base        = EDGE_5;
    end else if (six_h >= EDGE_4) begin
      s1_d.sector = SECTOR_4;
      base        = EDGE_4;
    end else if (six_h >= EDGE_3) begin
      s1_d.sector = SECTOR_3;
      base        = EDGE_3;
    end else if (six_h >= EDGE_2) begin
      s1_d.sector = SECTOR_2;
      base        = EDGE_2;
    end else if (six_h >= EDGE_1) begin
      s1_d.sector = SECTOR_1;
      base        = EDGE_1;
    end
    rem_full   = six_h - base;
    s1_d.rem   = rem_full[7:0];
    s1_d.sat   = sat_i;
    s1_d.val   = val_i;
    s1_d.last  = last_i;
    s1_d.num_p = 16'(val_i) * 16'(FULL8 - sat_i);
  end

  // Form the saturation weights for q and t
  assign prod_q = 16'(s1_q.sat) * 16'(s1_q.rem);
  assign prod_t = 16'(s1_q.sat) * 16'(FULL8 - s1_q.rem);

  always_comb begin
    s2_d.val      = s1_q.val;
    s2_d.last     = s1_q.last;
    s2_d.sat_zero = (s1_q.sat == '0);
    s2_d.sector   = s1_q.sector;
    s2_d.num_p    = s1_q.num_p;
    s2_d.wgt_q    = FULL16 - prod_q;
    s2_d.wgt_t    = FULL16 - prod_t;
  end

  // Advance valid bits when the next stage has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // Load payload with each accepted item
  always_ff @(posedge clk_i) begin
    if (valid_i && s1_ready) s1_q <= s1_d;
    if (s1_valid_q && s2_ready) s2_q <= s2_d;
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

endmodule

[sv/hsvbgr_back.sv]
module hsvbgr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hsvbgr_pkg::stage2_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsvbgr_pkg::pixel_t  data_o
);
  import hsvbgr_pkg::*;

  logic          s3_valid_q, s4_valid_q, s5_valid_q;
  logic          s3_ready, s4_ready, s5_ready;
  stage3_t       s3_q, s3_d;
  stage4_t       s4_q, s4_d;
  pixel_t        s5_q, s5_d;
  logic [15:0]   rnd_p;
  logic [32:0]   prod_p;
  logic [23:0]   rnd_q, rnd_t;
  logic [49:0]   prod_q, prod_t;
  logic [32:0]   prod_q2, prod_t2;
  logic [7:0]    lvl_v, lvl_p, lvl_q, lvl_t;

  assign s5_ready = !s5_valid_q || ready_i;
  assign s4_ready = !s4_valid_q || s5_ready;
  assign s3_ready = !s3_valid_q || s4_ready;
  assign ready_o  = s3_ready;

  // Level products; finish p with one divide by 255
  assign rnd_p  = data_i.num_p + 16'(RND8);
  assign prod_p = 33'(rnd_p) * 33'(RECIP_LO);

  always_comb begin
    s3_d.val      = data_i.val;
    s3_d.last     = data_i.last;
    s3_d.sat_zero = data_i.sat_zero;
    s3_d.sector   = data_i.sector;
    s3_d.lvl_p    = prod_p[RECIP_LO_SHIFT+8:RECIP_LO_SHIFT];
    s3_d.num_q    = 24'(data_i.val) * 24'(data_i.wgt_q);
    s3_d.num_t    = 24'(data_i.val) * 24'(data_i.wgt_t);
  end

  // First divide by 255 of q and t
  assign rnd_q  = s3_q.num_q + 24'(RND16);
  assign rnd_t  = s3_q.num_t + 24'(RND16);
  assign prod_q = 50'(rnd_q) * 50'(RECIP_HI);
  assign prod_t = 50'(rnd_t) * 50'(RECIP_HI);

  always_comb begin
    s4_d.val      = s3_q.val;
    s4_d.last     = s3_q.last;
    s4_d.sat_zero = s3_q.sat_zero;
    s4_d.sector   = s3_q.sector;
    s4_d.lvl_p    = s3_q.lvl_p;
    s4_d.quo_q    = prod_q[RECIP_HI_SHIFT+15:RECIP_HI_SHIFT];
    s4_d.quo_t    = prod_t[RECIP_HI_SHIFT+15:RECIP_HI_SHIFT];
  end

  // Second divide by 255, clip and route levels to channels
  assign prod_q2 = 33'(s4_q.quo_q) * 33'(RECIP_LO);
  assign prod_t2 = 33'(s4_q.quo_t) * 33'(RECIP_LO);
  assign lvl_v   = s4_q.val;
  assign lvl_p   = clip8(s4_q.lvl_p);
  assign lvl_q   = clip8(prod_q2[RECIP_LO_SHIFT+8:RECIP_LO_SHIFT]);
  assign lvl_t   = clip8(prod_t2[RECIP_LO_SHIFT+8:RECIP_LO_SHIFT]);

  always_comb begin
    s5_d.last = s4_q.last;
    case (s4_q.sector)
      SECTOR_0: begin
        s5_d.blue = lvl_p; s5_d.green = lvl_t; s5_d.red = lvl_v;
      end
      SECTOR_1: begin
        s5_d.blue = lvl_p; s5_d.green = lvl_v; s5_d.red = lvl_q;
      end
      SECTOR_2: begin
        s5_d.blue = lvl_t; s5_d.green = lvl_v; s5_d.red = lvl_p;
      end
      SECTOR_3: begin
        s5_d.blue = lvl_v; s5_d.green = lvl_q; s5_d.red = lvl_p;
      end
      SECTOR_4: begin
        s5_d.blue = lvl_v; s5_d.green = lvl_p; s5_d.red = lvl_t;
      end
      default: begin
        s5_d.blue = lvl_q; s5_d.green = lvl_p; s5_d.red = lvl_v;
      end
    endcase
    // Gray pixel: every channel at brightness
    if (s4_q.sat_zero) begin
      s5_d.blue  = lvl_v;
      s5_d.green = lvl_v;
      s5_d.red   = lvl_v;
    end
  end

  // Advance valid bits when the next stage has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s3_ready) s3_valid_q <= valid_i;
      if (s4_ready) s4_valid_q <= s3_valid_q;
      if (s5_ready) s5_valid_q <= s4_valid_q;
    end
  end

  // Load payload with each moving item
  always_ff @(posedge clk_i) begin
    if (valid_i && s3_ready) s3_q <= s3_d;
    if (s3_valid_q && s4_ready) s4_q <= s4_d;
    if (s4_valid_q && s5_ready) s5_q <= s5_d;
  end

  assign valid_o = s5_valid_q;
  assign data_o  = s5_q;

endmodule
